[design/assert_macros.svh]
// Assertion macros shared by the indexed sequential search modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[design/iss_pkg.sv]
// Shared types, codes and constants of the indexed sequential search block.
package iss_pkg;

    localparam int ARRAY_DEPTH_DEF = 16384;
    localparam int INDEX_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam int LEN_W     = 15;
    localparam int CNT_W     = 7;
    localparam int ADDR_W    = 14;
    localparam int POS_W     = 14;
    localparam int WORD_W    = 32;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [LEN_W-1:0] LEN_RESET = 15'd16384;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd50;

    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_COUNT  = 2'd1;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_BUILD,
        CMD_SEARCH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                   op;
        logic [ADDR_W-1:0]         addr;
        logic signed [WORD_W-1:0]  word;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic [CNT_W-1:0] rem;
    } div_rsp_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic [POS_W-1:0]         pos;
    } idx_entry_t;

endpackage

[design/iss_front.sv]
// Front end: input handshake, request decode and configuration registers.
module iss_front #(
    parameter int ARRAY_DEPTH = iss_pkg::ARRAY_DEPTH_DEF,
    parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [iss_pkg::REQ_W-1:0]            req_type,
    input  logic [iss_pkg::ADDR_W-1:0]           elem_addr,
    input  logic signed [iss_pkg::WORD_W-1:0]    elem_value,
    input  logic signed [iss_pkg::WORD_W-1:0]    search_key,
    input  logic                                 cfg_we,
    input  logic [iss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [iss_pkg::CFG_W-1:0]            cfg_data,
    input  iss_pkg::q_status_t                   q_status,
    output logic                                 q_push,
    output iss_pkg::cmd_t                        q_cmd,
    output iss_pkg::cfg_t                        cfg
);

    logic [iss_pkg::LEN_W-1:0] len_reg;
    logic [iss_pkg::CNT_W-1:0] cnt_reg;
    logic                      keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= iss_pkg::LEN_RESET;
            cnt_reg <= iss_pkg::CNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iss_pkg::CFG_ARRAY_LENGTH: len_reg <= cfg_data;
                iss_pkg::CFG_INDEX_COUNT:  cnt_reg <= cfg_data[iss_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp to the storage actually built.
    always_comb
    begin
        cfg.length = (32'(len_reg) > ARRAY_DEPTH) ? iss_pkg::LEN_W'(ARRAY_DEPTH) : len_reg;
        cfg.count  = (32'(cnt_reg) > INDEX_DEPTH) ? iss_pkg::CNT_W'(INDEX_DEPTH) : cnt_reg;
    end

    // Decode; drop unknown requests and writes beyond the array.
    always_comb
    begin
        q_cmd = '0;
        keep  = 1'b0;
        unique case (req_type)
            iss_pkg::REQ_WRITE:
            begin
                q_cmd.op   = iss_pkg::CMD_WRITE;
                q_cmd.addr = elem_addr;
                q_cmd.word = elem_value;
                keep       = 32'(elem_addr) < ARRAY_DEPTH;
            end
            iss_pkg::REQ_BUILD:
            begin
                q_cmd.op = iss_pkg::CMD_BUILD;
                keep     = 1'b1;
            end
            iss_pkg::REQ_SEARCH:
            begin
                q_cmd.op   = iss_pkg::CMD_SEARCH;
                q_cmd.word = search_key;
                keep       = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign in_ready = !q_status.full;
    assign q_push   = in_valid && in_ready && keep;

endmodule

[design/iss_queue.sv]
// Short command queue between the front end and the sequencer.
`include "assert_macros.svh"

module iss_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  iss_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output iss_pkg::cmd_t      head_cmd,
    output iss_pkg::q_status_t status
);

    localparam int DEPTH = iss_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    iss_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= CNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= CNT_W'(count_reg - 1'b1);
            end
        end
    end

    assign head_cmd     = entry_reg[rd_ptr_reg];
    assign status.full  = (32'(count_reg) == DEPTH);
    assign status.empty = (count_reg == '0);

    `ASSERT_CLK(a_pop_not_empty, clk, rst_n, pop |-> count_reg != '0, "pop from empty queue")
    `ASSERT_CLK(a_push_not_full, clk, rst_n, push |-> !status.full, "push into full queue")
    `ASSERT_ALWAYS(a_count_bound, clk, 32'(count_reg) <= DEPTH, "queue count overflow")

endmodule

[design/iss_divider.sv]
// Restoring divider, one quotient bit per cycle, for index spacing.
module iss_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  iss_pkg::div_req_t req,
    output iss_pkg::div_rsp_t rsp
);

    localparam int LW     = iss_pkg::LEN_W;
    localparam int DW     = iss_pkg::CNT_W;
    localparam int STEP_W = $clog2(LW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [LW-1:0]     quo_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     divisor_reg;
    logic [DW:0]       shifted;
    logic [DW:0]       diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[LW-1]};
    assign ge      = shifted >= {1'b0, divisor_reg};
    assign diff    = shifted - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                step_reg    <= '0;
                quo_reg     <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                quo_reg  <= {quo_reg[LW-2:0], ge};
                rem_reg  <= ge ? diff[DW-1:0] : shifted[DW-1:0];
                step_reg <= STEP_W'(step_reg + 1'b1);
                if (step_reg == STEP_W'(LW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

[design/iss_back.sv]
// Back end: element and index memories, build and search sequencer, result register.
`include "assert_macros.svh"

module iss_back #(
    parameter int ARRAY_DEPTH = iss_pkg::ARRAY_DEPTH_DEF,
    parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iss_pkg::cfg_t                 cfg,
    input  iss_pkg::q_status_t            q_status,
    input  iss_pkg::cmd_t                 q_head,
    output logic                          q_pop,
    output iss_pkg::div_req_t             div_req,
    input  iss_pkg::div_rsp_t             div_rsp,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          found,
    output logic [iss_pkg::POS_W-1:0]     position
);

    localparam int AW = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
    localparam int IW = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int LW = iss_pkg::LEN_W;
    localparam int CW = iss_pkg::CNT_W;
    localparam int PW = iss_pkg::POS_W;
    localparam int WW = iss_pkg::WORD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD_DIV,
        S_BUILD_RD,
        S_BUILD_WR,
        S_IDX_RD,
        S_IDX_CMP,
        S_DAT_RD,
        S_DAT_CMP,
        S_DONE
    } state_t;

    logic [WW-1:0]       data_mem [ARRAY_DEPTH];
    iss_pkg::idx_entry_t idx_mem  [INDEX_DEPTH];

    state_t                state_reg;
    logic [CW-1:0]         i_reg;
    logic [LW-1:0]         walk_reg;
    logic [CW-1:0]         frac_reg;
    logic [LW-1:0]         step_q_reg;
    logic [CW-1:0]         step_r_reg;
    logic signed [WW-1:0]  key_reg;
    logic [PW-1:0]         last_pos_reg;
    logic                  hit_reg;
    logic                  div_start_reg;
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [PW-1:0]         position_reg;

    logic signed [WW-1:0]  data_rd;
    iss_pkg::idx_entry_t   idx_rd;
    logic                  data_we;
    logic                  idx_we;
    logic [CW:0]           frac_sum;
    logic                  frac_wrap;
    logic                  key_lt_idx;
    logic                  data_lt_key;
    logic                  last_entry;

    // Memories: one write and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[AW'(q_head.addr)] <= q_head.word;
        end
        data_rd <= data_mem[AW'(walk_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_mem[IW'(i_reg)] <= '{key: data_rd, pos: walk_reg[PW-1:0]};
        end
        idx_rd <= idx_mem[IW'(i_reg)];
    end

    assign q_pop   = (state_reg == S_IDLE) && !q_status.empty;
    assign data_we = q_pop && (q_head.op == iss_pkg::CMD_WRITE);
    assign idx_we  = (state_reg == S_BUILD_WR);

    // Spacing step: advance by quotient, carry the remainder fraction.
    assign frac_sum    = {1'b0, frac_reg} + {1'b0, step_r_reg};
    assign frac_wrap   = frac_sum >= {1'b0, cfg.count};
    assign last_entry  = CW'(i_reg + 1'b1) == cfg.count;
    assign key_lt_idx  = key_reg < idx_rd.key;
    assign data_lt_key = data_rd < key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            walk_reg      <= '0;
            frac_reg      <= '0;
            step_q_reg    <= '0;
            step_r_reg    <= '0;
            key_reg       <= '0;
            last_pos_reg  <= '0;
            hit_reg       <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            position_reg  <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (q_head.op)
                            iss_pkg::CMD_WRITE: ;
                            iss_pkg::CMD_BUILD:
                            begin
                                if (cfg.count != '0)
                                begin
                                    div_start_reg <= 1'b1;
                                    state_reg     <= S_BUILD_DIV;
                                end
                            end
                            iss_pkg::CMD_SEARCH:
                            begin
                                key_reg   <= q_head.word;
                                i_reg     <= '0;
                                state_reg <= S_IDX_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_BUILD_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        step_q_reg <= div_rsp.quot;
                        step_r_reg <= div_rsp.rem;
                        walk_reg   <= '0;
                        frac_reg   <= '0;
                        i_reg      <= '0;
                        state_reg  <= S_BUILD_RD;
                    end
                end
                S_BUILD_RD:
                begin
                    state_reg <= S_BUILD_WR;
                end
                S_BUILD_WR:
                begin
                    if (last_entry)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= CW'(i_reg + 1'b1);
                        walk_reg  <= LW'(walk_reg + step_q_reg + LW'(frac_wrap));
                        frac_reg  <= frac_wrap ? CW'(frac_sum - {1'b0, cfg.count})
                                               : frac_sum[CW-1:0];
                        state_reg <= S_BUILD_RD;
                    end
                end
                S_IDX_RD:
                begin
                    if (i_reg == cfg.count)
                    begin
                        if (i_reg == '0)
                        begin
                            hit_reg   <= 1'b0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            walk_reg  <= LW'(last_pos_reg);
                            state_reg <= S_DAT_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDX_CMP;
                    end
                end
                S_IDX_CMP:
                begin
                    if (!key_lt_idx)
                    begin
                        last_pos_reg <= idx_rd.pos;
                        i_reg        <= CW'(i_reg + 1'b1);
                        state_reg    <= S_IDX_RD;
                    end
                    else if (i_reg == '0)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        walk_reg  <= LW'(last_pos_reg);
                        state_reg <= S_DAT_RD;
                    end
                end
                S_DAT_RD:
                begin
                    if (walk_reg >= cfg.length)
                    begin
                        hit_reg   <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DAT_CMP;
                    end
                end
                S_DAT_CMP:
                begin
                    if (data_lt_key)
                    begin
                        walk_reg  <= LW'(walk_reg + 1'b1);
                        state_reg <= S_DAT_RD;
                    end
                    else
                    begin
                        hit_reg   <= (data_rd == key_reg);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        position_reg  <= hit_reg ? walk_reg[PW-1:0] : '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = cfg.length;
    assign div_req.divisor  = cfg.count;

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    `ASSERT_CLK(a_result_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg) == S_DONE, "result raised outside done state")
    `ASSERT_CLK(a_miss_pos_zero, clk, rst_n, out_valid_reg && !found_reg |-> position_reg == '0, "miss with nonzero position")
    `ASSERT_CLK(a_idx_write_range, clk, rst_n, idx_we |-> i_reg < cfg.count, "index write beyond count")

endmodule

[design/indexed_sequential_search_core.sv]
// Indexed sequential search: top level joining front end, queue, divider and sequencer.
// Write item: passes through the queue and is written to the element memory when popped; no result.
// Build item: serial 15-step divider, then one read/write pair per entry.
// Search item: index entries walked, then elements walked, each a registered memory read and compare.
// One item at a time in the sequencer; up to two items wait in the queue meanwhile.
// Reset: registers go to array_length 16384 and index_count 50; memories are not cleared.
module indexed_sequential_search_core #(
    parameter int ARRAY_DEPTH = iss_pkg::ARRAY_DEPTH_DEF,
    parameter int INDEX_DEPTH = iss_pkg::INDEX_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [iss_pkg::REQ_W-1:0]         req_type,
    input  logic [iss_pkg::ADDR_W-1:0]        elem_addr,
    input  logic signed [iss_pkg::WORD_W-1:0] elem_value,
    input  logic signed [iss_pkg::WORD_W-1:0] search_key,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              found,
    output logic [iss_pkg::POS_W-1:0]         position,
    input  logic                              cfg_we,
    input  logic [iss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iss_pkg::CFG_W-1:0]         cfg_data
);

    // Front to queue: decoded item and push strobe.
    iss_pkg::cmd_t      push_cmd;
    logic               push;
    // Queue to back end: head item and fill status.
    iss_pkg::cmd_t      head_cmd;
    iss_pkg::q_status_t q_status;
    logic               pop;
    // Clamped configuration, to be kept steady by the user while the block is idle; the block does not enforce it.
    iss_pkg::cfg_t      cfg;
    // Divider handshake for the index spacing.
    iss_pkg::div_req_t  div_req;
    iss_pkg::div_rsp_t  div_rsp;

    // Accept items, decode them and hold the configuration registers.
    iss_front #(
        .ARRAY_DEPTH(ARRAY_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .elem_addr (elem_addr),
        .elem_value(elem_value),
        .search_key(search_key),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_push    (push),
        .q_cmd     (push_cmd),
        .cfg       (cfg)
    );

    // Hold decoded items until the sequencer is free.
    iss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head_cmd(head_cmd),
        .status  (q_status)
    );

    // Work out length / count once per build.
    iss_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // Carry out writes, builds and searches; drive the result register.
    iss_back #(
        .ARRAY_DEPTH(ARRAY_DEPTH),
        .INDEX_DEPTH(INDEX_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_status (q_status),
        .q_head   (head_cmd),
        .q_pop    (pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found    (found),
        .position (position)
    );

endmodule
